// ===== hdl/cis_pkg.sv =====
// ----------------------------------------------------------------------------
// cis_pkg
// Shared constants and types for the coalescing interval set.
// ----------------------------------------------------------------------------
package cis_pkg;

    localparam int MAX_RANGES_DEF = 64;
    localparam int NUM_W          = 32;
    localparam int COUNT_OUT_W    = 7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_DECIDE,
        ST_MSH_CHK,
        ST_MSH_WR,
        ST_ISH_CHK,
        ST_ISH_WR,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX_P1,
        RA_IDX_M1
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_MERGE,
        WR_JOIN_ABOVE,
        WR_JOIN_BELOW,
        WR_SHIFT,
        WR_NEW
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_KEEP,
        IDX_INC,
        IDX_DEC,
        IDX_POS,
        IDX_N
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic    load;
        logic    rd;
        t_rd_sel rd_sel;
        logic    scan_cmp;
        logic    wr;
        t_wr_sel wr_sel;
        t_idx_op idx_op;
        t_cnt_op cnt_op;
        logic    res_set;
        logic    ovf;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic idx_eq_n;
        logic start_lt;
        logic covered;
        logic join_below;
        logic join_above;
        logic full;
        logic msh_done;
        logic ish_done;
    } t_stat;

endpackage

// ===== hdl/cis_ctrl.sv =====
// ----------------------------------------------------------------------------
// cis_ctrl
// Sequencer: scan for position, then update the range table in place.
// ----------------------------------------------------------------------------
module cis_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall,
    output logic            o_stall,
    output logic            o_valid,
    input  cis_pkg::t_stat  i_stat,
    output cis_pkg::t_cmd   o_cmd
);

    cis_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cis_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cis_pkg::ST_IDLE: begin
                if (i_valid) n_state = cis_pkg::ST_RD;
            end
            cis_pkg::ST_RD: begin
                n_state = i_stat.idx_eq_n ? cis_pkg::ST_DECIDE : cis_pkg::ST_CMP;
            end
            cis_pkg::ST_CMP: begin
                n_state = i_stat.start_lt ? cis_pkg::ST_RD : cis_pkg::ST_DECIDE;
            end
            cis_pkg::ST_DECIDE: begin
                if (i_stat.op || i_stat.covered) begin
                    n_state = cis_pkg::ST_OUT;
                end else if (i_stat.join_below && i_stat.join_above) begin
                    n_state = cis_pkg::ST_MSH_CHK;
                end else if (i_stat.join_below || i_stat.join_above || i_stat.full) begin
                    n_state = cis_pkg::ST_OUT;
                end else begin
                    n_state = cis_pkg::ST_ISH_CHK;
                end
            end
            cis_pkg::ST_MSH_CHK: begin
                n_state = i_stat.msh_done ? cis_pkg::ST_OUT : cis_pkg::ST_MSH_WR;
            end
            cis_pkg::ST_MSH_WR:  n_state = cis_pkg::ST_MSH_CHK;
            cis_pkg::ST_ISH_CHK: begin
                n_state = i_stat.ish_done ? cis_pkg::ST_OUT : cis_pkg::ST_ISH_WR;
            end
            cis_pkg::ST_ISH_WR:  n_state = cis_pkg::ST_ISH_CHK;
            cis_pkg::ST_OUT: begin
                if (!i_stall) n_state = cis_pkg::ST_IDLE;
            end
            default: n_state = cis_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = cis_pkg::RA_IDX;
        o_cmd.wr_sel = cis_pkg::WR_NEW;
        o_cmd.idx_op = cis_pkg::IDX_KEEP;
        o_cmd.cnt_op = cis_pkg::CNT_KEEP;
        o_stall      = 1'b1;
        o_valid      = 1'b0;
        unique case (r_state)
            cis_pkg::ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            cis_pkg::ST_RD: begin
                o_cmd.rd = !i_stat.idx_eq_n;
            end
            cis_pkg::ST_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                if (i_stat.start_lt) o_cmd.idx_op = cis_pkg::IDX_INC;
            end
            cis_pkg::ST_DECIDE: begin
                o_cmd.res_set = 1'b1;
                if (!i_stat.op && !i_stat.covered) begin
                    if (i_stat.join_below && i_stat.join_above) begin
                        o_cmd.wr     = 1'b1;
                        o_cmd.wr_sel = cis_pkg::WR_MERGE;
                        o_cmd.idx_op = cis_pkg::IDX_POS;
                    end else if (i_stat.join_above) begin
                        o_cmd.wr     = 1'b1;
                        o_cmd.wr_sel = cis_pkg::WR_JOIN_ABOVE;
                    end else if (i_stat.join_below) begin
                        o_cmd.wr     = 1'b1;
                        o_cmd.wr_sel = cis_pkg::WR_JOIN_BELOW;
                    end else if (i_stat.full) begin
                        o_cmd.ovf = 1'b1;
                    end else begin
                        o_cmd.idx_op = cis_pkg::IDX_N;
                    end
                end
            end
            cis_pkg::ST_MSH_CHK: begin
                if (i_stat.msh_done) begin
                    o_cmd.cnt_op = cis_pkg::CNT_DEC;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = cis_pkg::RA_IDX_P1;
                end
            end
            cis_pkg::ST_MSH_WR: begin
                o_cmd.wr     = 1'b1;
                o_cmd.wr_sel = cis_pkg::WR_SHIFT;
                o_cmd.idx_op = cis_pkg::IDX_INC;
            end
            cis_pkg::ST_ISH_CHK: begin
                if (i_stat.ish_done) begin
                    o_cmd.wr     = 1'b1;
                    o_cmd.wr_sel = cis_pkg::WR_NEW;
                    o_cmd.cnt_op = cis_pkg::CNT_INC;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = cis_pkg::RA_IDX_M1;
                end
            end
            cis_pkg::ST_ISH_WR: begin
                o_cmd.wr     = 1'b1;
                o_cmd.wr_sel = cis_pkg::WR_SHIFT;
                o_cmd.idx_op = cis_pkg::IDX_DEC;
            end
            cis_pkg::ST_OUT: begin
                o_valid = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/cis_dpath.sv =====
// ----------------------------------------------------------------------------
// cis_dpath
// Range table memory, scan registers, boundary compares and result registers.
// ----------------------------------------------------------------------------
module cis_dpath #(
    parameter int MAX_RANGES = cis_pkg::MAX_RANGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_op,
    input  logic signed [cis_pkg::NUM_W-1:0]  i_number,
    input  cis_pkg::t_cmd                     i_cmd,
    output cis_pkg::t_stat                    o_stat,
    output logic                              o_seen,
    output logic [cis_pkg::COUNT_OUT_W-1:0]   o_range_count,
    output logic                              o_overflow
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int NW = cis_pkg::NUM_W;

    // entry = {start, end}
    logic [2*NW-1:0] mem [MAX_RANGES];

    logic                 r_op;
    logic signed [NW-1:0] r_num;
    logic [2*NW-1:0]      r_q;
    logic [2*NW-1:0]      r_below;
    logic [2*NW-1:0]      r_above;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_pos;
    logic [CW-1:0]        r_cnt;
    logic                 r_seen;
    logic                 r_ovf;

    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        wr_addr;
    logic [2*NW-1:0]      wr_data;
    logic signed [NW-1:0] q_start;
    logic signed [NW-1:0] b_start, b_end, a_start, a_end;
    logic                 has_below, has_above;
    logic signed [NW:0]   b_end_p1, a_start_m1, num_x;

    assign q_start = r_q[2*NW-1:NW];
    assign b_start = r_below[2*NW-1:NW];
    assign b_end   = r_below[NW-1:0];
    assign a_start = r_above[2*NW-1:NW];
    assign a_end   = r_above[NW-1:0];

    assign has_below  = (r_pos != '0);
    assign has_above  = (r_pos < r_cnt);
    assign num_x      = {r_num[NW-1], r_num};
    assign b_end_p1   = {b_end[NW-1], b_end} + (NW+1)'(1);
    assign a_start_m1 = {a_start[NW-1], a_start} - (NW+1)'(1);

    always_comb begin
        o_stat.op         = r_op;
        o_stat.idx_eq_n   = (r_idx == r_cnt);
        o_stat.start_lt   = (q_start < r_num);
        o_stat.covered    = (has_above && a_start == r_num) ||
                            (has_below && b_end >= r_num);
        o_stat.join_below = has_below && (b_end_p1 == num_x);
        o_stat.join_above = has_above && (a_start_m1 == num_x);
        o_stat.full       = (r_cnt == CW'(MAX_RANGES));
        o_stat.msh_done   = ({1'b0, r_idx} + (CW+1)'(1)) >= {1'b0, r_cnt};
        o_stat.ish_done   = (r_idx == r_pos);
    end

    always_comb begin
        case (i_cmd.rd_sel)
            cis_pkg::RA_IDX_P1: rd_addr = IW'(r_idx + CW'(1));
            cis_pkg::RA_IDX_M1: rd_addr = IW'(r_idx - CW'(1));
            default:            rd_addr = IW'(r_idx);
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            cis_pkg::WR_MERGE: begin
                wr_addr = IW'(r_pos - CW'(1));
                wr_data = {b_start, a_end};
            end
            cis_pkg::WR_JOIN_ABOVE: begin
                wr_addr = IW'(r_pos);
                wr_data = {r_num, a_end};
            end
            cis_pkg::WR_JOIN_BELOW: begin
                wr_addr = IW'(r_pos - CW'(1));
                wr_data = {b_start, r_num};
            end
            cis_pkg::WR_SHIFT: begin
                wr_addr = IW'(r_idx);
                wr_data = r_q;
            end
            default: begin
                wr_addr = IW'(r_pos);
                wr_data = {r_num, r_num};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) mem[wr_addr] <= wr_data;
        if (i_cmd.rd) r_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_num <= i_number;
        end
        if (i_cmd.scan_cmp) begin
            if (o_stat.start_lt) begin
                r_below <= r_q;
            end else begin
                r_above <= r_q;
            end
        end
        if (i_cmd.res_set) begin
            r_seen <= o_stat.covered;
            r_ovf  <= i_cmd.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_pos <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pos <= '0;
            end else if (i_cmd.scan_cmp) begin
                r_pos <= o_stat.start_lt ? r_idx + CW'(1) : r_idx;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else begin
                case (i_cmd.idx_op)
                    cis_pkg::IDX_INC: r_idx <= r_idx + CW'(1);
                    cis_pkg::IDX_DEC: r_idx <= r_idx - CW'(1);
                    cis_pkg::IDX_POS: r_idx <= r_pos;
                    cis_pkg::IDX_N:   r_idx <= r_cnt;
                    default:          r_idx <= r_idx;
                endcase
            end
            case (i_cmd.cnt_op)
                cis_pkg::CNT_INC: r_cnt <= r_cnt + CW'(1);
                cis_pkg::CNT_DEC: r_cnt <= r_cnt - CW'(1);
                default:          r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_seen        = r_seen;
    assign o_overflow    = r_ovf;
    assign o_range_count = cis_pkg::COUNT_OUT_W'(r_cnt);

endmodule

// ===== hdl/coalescing_interval_set.sv =====
// ----------------------------------------------------------------------------
// coalescing_interval_set
// Sorted set of disjoint signed ranges with add, merge and query.
// ----------------------------------------------------------------------------
// One transaction at a time. The ranges sit in a table with one read and one
// write port, read one entry at a time. The position scan reads and compares
// each range below the number, then the first range at or above it, if any.
// The decide state also does an extend or merge write. A merge then shifts each
// range above the upper joined range down one entry, with a read and a write
// state per range. An insert shifts each range above it up one entry in the
// same way, then writes the new range. The result is held until the output is
// not stalled. Ranges below and above add up to at most the range count. The
// input is stalled from acceptance until the result transaction completes.
module coalescing_interval_set #(
    parameter int MAX_RANGES = cis_pkg::MAX_RANGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_op,
    input  logic signed [cis_pkg::NUM_W-1:0]  i_number,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_seen,
    output logic [cis_pkg::COUNT_OUT_W-1:0]   o_range_count,
    output logic                              o_overflow
);

    cis_pkg::t_cmd  cmd;
    cis_pkg::t_stat stat;

    cis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cis_dpath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_number      (i_number),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_seen        (o_seen),
        .o_range_count (o_range_count),
        .o_overflow    (o_overflow)
    );

endmodule

// ===== tb/coalescing_interval_set_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coalescing_interval_set_test
// Self-checking bench: drives add and query transactions with random idling
// on both channels, predicts every result from a local range table and
// compares each output transaction field by field.
// ----------------------------------------------------------------------------
module coalescing_interval_set_test;

    localparam int NRANGES = cis_pkg::MAX_RANGES_DEF;
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam int N_RANDOM = 650;

    typedef struct packed {
        logic        op;
        logic [31:0] number;
    } t_item;

    typedef struct packed {
        logic       seen;
        logic [6:0] range_count;
        logic       overflow;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    logic signed [31:0] i_number;
    logic        o_valid;
    logic        i_stall;
    logic        o_seen;
    logic [6:0]  o_range_count;
    logic        o_overflow;

    coalescing_interval_set DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_number      (i_number),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_seen        (o_seen),
        .o_range_count (o_range_count),
        .o_overflow    (o_overflow)
    );

    t_item    pending_items[$];
    t_outcome expected_outcomes[$];
    int       error_count = 0;
    bit       calm_phase = 0;
    bit       src_pause = 0;
    int       sink_holdoff = 0;

    // local copy of the range table
    longint   tbl_lo[NRANGES];
    longint   tbl_hi[NRANGES];
    int       tbl_used = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic t_outcome predict_range_update(t_item it);
        t_outcome res;
        longint num;
        int pos;
        int n;
        bit covered;
        bit jb;
        bit ja;
        num = longint'($signed(it.number));
        n = tbl_used;
        pos = 0;
        res = '0;
        while (pos < n && tbl_lo[pos] < num) pos++;
        covered = (pos < n && tbl_lo[pos] == num) || (pos > 0 && tbl_hi[pos-1] >= num);
        if (it.op == OP_ADD && !covered) begin
            jb = pos > 0 && tbl_hi[pos-1] + 1 == num;
            ja = pos < n && tbl_lo[pos] - 1 == num;
            if (jb && ja) begin
                tbl_hi[pos-1] = tbl_hi[pos];
                for (int k = pos; k + 1 < n; k++) begin
                    tbl_lo[k] = tbl_lo[k+1];
                    tbl_hi[k] = tbl_hi[k+1];
                end
                n--;
            end else if (ja) begin
                tbl_lo[pos] = num;
            end else if (jb) begin
                tbl_hi[pos-1] = num;
            end else if (n >= NRANGES) begin
                res.overflow = 1'b1;
            end else begin
                for (int k = n; k > pos; k--) begin
                    tbl_lo[k] = tbl_lo[k-1];
                    tbl_hi[k] = tbl_hi[k-1];
                end
                tbl_lo[pos] = num;
                tbl_hi[pos] = num;
                n++;
            end
            tbl_used = n;
        end
        res.seen = covered;
        res.range_count = tbl_used[6:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic push_item(logic op, logic [31:0] number);
        t_item it;
        it.op = op;
        it.number = number;
        pending_items.push_back(it);
    endtask

    // driver: predicts on acceptance
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_outcomes.push_back(
                    predict_range_update('{op: i_op, number: i_number}));
                void'(pending_items.pop_front());
            end
            if (!(i_valid && o_stall)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (src_pause || pending_items.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 10);
                    i_valid <= 1'b0;
                end else begin
                    i_valid  <= 1'b1;
                    i_op     <= pending_items[0].op;
                    i_number <= pending_items[0].number;
                end
            end
        end
    end

    // monitor and receiver stall
    int sink_gap = 0;
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", '0, '0);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (o_seen !== want.seen)
                        report_mismatch("seen", 32'(o_seen), 32'(want.seen));
                    if (o_range_count !== want.range_count)
                        report_mismatch("range_count", 32'(o_range_count),
                                        32'(want.range_count));
                    if (o_overflow !== want.overflow)
                        report_mismatch("overflow", 32'(o_overflow), 32'(want.overflow));
                end
            end
            if (sink_holdoff > 0) begin
                sink_holdoff--;
                i_stall <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_stall <= 1'b1;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 10);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic [31:0] pick_number(int mode);
        case (mode)
            0: return $urandom_range(0, 200) - 100;
            1: return 32'h7FFF_FFFF - $urandom_range(0, 60);
            2: return 32'h8000_0000 + $urandom_range(0, 60);
            3: return $urandom_range(0, 1200) - 600;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] v;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_stall  = 1'b0;
        i_op     = OP_ADD;
        i_number = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, extend up and down, merge, covered add, queries
        push_item(OP_QUERY, 32'h8000_0000);
        push_item(OP_ADD,   32'h8000_0000);
        push_item(OP_ADD,   32'h8000_0000);
        push_item(OP_ADD,   32'h7FFF_FFFF);
        push_item(OP_ADD,   32'h7FFF_FFFE);
        push_item(OP_ADD,   32'h8000_0001);
        push_item(OP_QUERY, 32'h7FFF_FFFF);
        push_item(OP_ADD,   32'd10);
        push_item(OP_ADD,   32'd12);
        push_item(OP_ADD,   32'd11);
        push_item(OP_QUERY, 32'd11);
        push_item(OP_ADD,   32'd9);
        push_item(OP_ADD,   32'hFFFF_FFFF);
        push_item(OP_ADD,   32'd0);
        push_item(OP_QUERY, 32'd5);
        push_item(OP_QUERY, 32'hAAAA_AAAA);
        push_item(OP_QUERY, 32'h5555_5555);
        wait (pending_items.size() == 0);

        // fill table past capacity with even numbers: overflow while full
        for (int k = 0; k < 70; k++) push_item(OP_ADD, 32'd1000 + 2 * k);
        sink_holdoff = 300;
        wait (pending_items.size() == 0);
        // extend and merge while full
        for (int k = 0; k < 8; k++) push_item(OP_ADD, 32'd1001 + 2 * k);
        push_item(OP_ADD, 32'd999);
        push_item(OP_ADD, 32'd5);
        wait (pending_items.size() == 0);
        src_pause = 1'b1;
        wait (expected_outcomes.size() == 0 && !i_valid);
        src_pause = 1'b0;
        // clear the table state by bridging is impossible; random part keeps merging
        for (int k = 0; k < N_RANDOM; k++) begin
            v = pick_number($urandom_range(0, 4));
            push_item($urandom_range(0, 3) == 0 ? OP_QUERY : OP_ADD, v);
            if (k == N_RANDOM - 120) begin
                wait (pending_items.size() < 20);
                calm_phase = 1'b1;
            end
        end
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_outcomes.size() == 0);
        repeat (4 * NRANGES + 20) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cis_pkg.sv
hdl/cis_ctrl.sv
hdl/cis_dpath.sv
hdl/coalescing_interval_set.sv
tb/coalescing_interval_set_test.sv
